FILE: hw/rtl/spwm_pkg.sv
package spwm_pkg;

	localparam int PHASE_BITS    = 32;
	localparam int SINE_ENTRIES  = 256;
	localparam int SAMPLE_BITS   = 16;
	localparam int ADC_BITS      = 12;
	localparam int IDX_BITS      = $clog2(SINE_ENTRIES);
	localparam int AMP_BITS      = 15;
	localparam int GAIN_BITS     = 16;
	localparam int STEP_CFG_BITS = 31;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 31;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_BITS-1:0] REG_SINE_STEP_GAIN    = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_LOW_SPEED_STEP    = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_POT_THRESHOLD     = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_CARRIER_STEP      = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_SINE_AMPLITUDE    = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_CARRIER_AMPLITUDE = 3'd5;

	localparam logic [GAIN_BITS-1:0]     RST_SINE_STEP_GAIN    = 16'd8590;
	localparam logic [STEP_CFG_BITS-1:0] RST_LOW_SPEED_STEP    = 31'd1288490;
	localparam logic [ADC_BITS-1:0]      RST_POT_THRESHOLD     = 12'd200;
	localparam logic [STEP_CFG_BITS-1:0] RST_CARRIER_STEP      = 31'd429496730;
	localparam logic [AMP_BITS-1:0]      RST_SINE_AMPLITUDE    = 15'd32767;
	localparam logic [AMP_BITS-1:0]      RST_CARRIER_AMPLITUDE = 15'd22938;
	localparam logic [PHASE_BITS-1:0]    RST_SINE_STEP         = PHASE_BITS'(64'd2147484);

	// -120 and -240 degree offsets
	localparam logic [PHASE_BITS-1:0] PHASE_THIRD     = PHASE_BITS'((65'd1 << PHASE_BITS) / 3);
	localparam logic [PHASE_BITS-1:0] PHASE_TWO_THIRD = PHASE_BITS'(((65'd1 << PHASE_BITS) * 2) / 3);

	localparam longint ONE30 = 64'sd1 << 30;
	localparam longint SMAX  = (64'sd1 << (SAMPLE_BITS - 1)) - 1;

	typedef struct packed {
		logic                pot_valid;
		logic [ADC_BITS-1:0] pot_value;
	} in_t;

	typedef struct packed {
		logic pwm_a;
		logic pwm_b;
		logic pwm_c;
		logic step_changed;
	} out_t;

	typedef struct packed {
		logic [GAIN_BITS-1:0]     sine_step_gain;
		logic [STEP_CFG_BITS-1:0] low_speed_step;
		logic [ADC_BITS-1:0]      pot_threshold;
		logic [STEP_CFG_BITS-1:0] carrier_step;
		logic [AMP_BITS-1:0]      sine_amplitude;
		logic [AMP_BITS-1:0]      carrier_amplitude;
	} cfg_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sa;
		logic signed [SAMPLE_BITS-1:0] sb;
		logic signed [SAMPLE_BITS-1:0] sc;
		logic                          car_neg;
		logic [SAMPLE_BITS-2:0]        car_mag;
		logic                          step_changed;
	} wave_t;

	typedef logic signed [SAMPLE_BITS-1:0] sine_lut_t [SINE_ENTRIES];

	// sin(pi/2 * u), u and result in Q30
	function automatic longint quarter_sine(input longint u);
		longint u2;
		longint acc;
		u2 = (u * u) / ONE30;
		acc = 172271;
		acc = -5026995 + (acc * u2) / ONE30;
		acc = 85569306 + (acc * u2) / ONE30;
		acc = -693598668 + (acc * u2) / ONE30;
		acc = 1686629713 + (acc * u2) / ONE30;
		acc = (acc * u) / ONE30;
		if (acc < 0) acc = 0;
		if (acc > ONE30) acc = ONE30;
		return acc;
	endfunction

	function automatic sine_lut_t build_sine_lut();
		sine_lut_t lut;
		longint    k4;
		longint    q;
		longint    rem;
		longint    u;
		longint    mag;
		int        i;
		for (i = 0; i < SINE_ENTRIES; i++) begin
			k4 = longint'(i) * 4;
			q = (k4 / SINE_ENTRIES) % 4;
			rem = k4 % SINE_ENTRIES;
			u = (rem << 30) / SINE_ENTRIES;
			if (q % 2 == 1) u = ONE30 - u;
			mag = (quarter_sine(u) * SMAX + ONE30 / 2) / ONE30;
			lut[i] = SAMPLE_BITS'((q >= 2) ? -mag : mag);
		end
		return lut;
	endfunction

	localparam sine_lut_t SINE_LUT = build_sine_lut();

	// magnitude times Q0.15 amplitude, truncated toward zero, sign restored
	function automatic logic signed [SAMPLE_BITS-1:0] scale_amp(
		input logic                   neg,
		input logic [SAMPLE_BITS-2:0] mag,
		input logic [AMP_BITS-1:0]    amp
	);
		logic [SAMPLE_BITS+AMP_BITS-2:0] prod;
		logic signed [SAMPLE_BITS-1:0]   res;
		prod = mag * amp;
		res = signed'({1'b0, prod[AMP_BITS +: SAMPLE_BITS-1]});
		return neg ? -res : res;
	endfunction

endpackage

FILE: hw/rtl/spwm_cfg.sv
module spwm_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [spwm_pkg::CFG_IDX_BITS-1:0]    wr_index,
	input  logic [spwm_pkg::CFG_DATA_BITS-1:0]   wr_data,
	output spwm_pkg::cfg_t                       cfg
);
	import spwm_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sine_step_gain    <= RST_SINE_STEP_GAIN;
			cfg_q.low_speed_step    <= RST_LOW_SPEED_STEP;
			cfg_q.pot_threshold     <= RST_POT_THRESHOLD;
			cfg_q.carrier_step      <= RST_CARRIER_STEP;
			cfg_q.sine_amplitude    <= RST_SINE_AMPLITUDE;
			cfg_q.carrier_amplitude <= RST_CARRIER_AMPLITUDE;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_SINE_STEP_GAIN:    cfg_q.sine_step_gain    <= wr_data[GAIN_BITS-1:0];
				REG_LOW_SPEED_STEP:    cfg_q.low_speed_step    <= wr_data[STEP_CFG_BITS-1:0];
				REG_POT_THRESHOLD:     cfg_q.pot_threshold     <= wr_data[ADC_BITS-1:0];
				REG_CARRIER_STEP:      cfg_q.carrier_step      <= wr_data[STEP_CFG_BITS-1:0];
				REG_SINE_AMPLITUDE:    cfg_q.sine_amplitude    <= wr_data[AMP_BITS-1:0];
				REG_CARRIER_AMPLITUDE: cfg_q.carrier_amplitude <= wr_data[AMP_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: hw/rtl/spwm_phase.sv
module spwm_phase (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               adv,
	input  spwm_pkg::in_t                      item,
	input  spwm_pkg::cfg_t                     cfg,
	output logic [spwm_pkg::PHASE_BITS-1:0]    sine_phase,
	output logic [spwm_pkg::PHASE_BITS-1:0]    carrier_phase,
	output logic                               step_changed
);
	import spwm_pkg::*;

	logic [PHASE_BITS-1:0] sine_phase_q;
	logic [PHASE_BITS-1:0] carrier_phase_q;
	logic [PHASE_BITS-1:0] sine_step_q;
	logic [ADC_BITS-1:0]   last_pot_q;

	logic                  below_thr;
	logic                  outside_band;
	logic [ADC_BITS+3:0]   pot_x10;
	logic [ADC_BITS+3:0]   old_x9;
	logic [ADC_BITS+3:0]   old_x11;
	logic [PHASE_BITS-1:0] step_next;

	always_comb begin
		pot_x10 = (ADC_BITS+4)'(item.pot_value) * (ADC_BITS+4)'(10);
		old_x9  = (ADC_BITS+4)'(last_pot_q) * (ADC_BITS+4)'(9);
		old_x11 = (ADC_BITS+4)'(last_pot_q) * (ADC_BITS+4)'(11);
		below_thr = item.pot_value < cfg.pot_threshold;
		// +-10 percent hysteresis band around the last accepted reading
		outside_band = (pot_x10 < old_x9) || (pot_x10 > old_x11);
		step_changed = item.pot_valid && (below_thr || outside_band);
		step_next = sine_step_q;
		if (item.pot_valid) begin
			priority if (below_thr)
				step_next = PHASE_BITS'(cfg.low_speed_step);
			else if (outside_band)
				step_next = PHASE_BITS'(item.pot_value * cfg.sine_step_gain);
			else
				step_next = sine_step_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sine_phase_q    <= '0;
			carrier_phase_q <= '0;
			sine_step_q     <= RST_SINE_STEP;
			last_pot_q      <= '0;
		end else if (adv) begin
			sine_step_q     <= step_next;
			sine_phase_q    <= sine_phase_q + step_next;
			carrier_phase_q <= carrier_phase_q + PHASE_BITS'(cfg.carrier_step);
			if (step_changed)
				last_pot_q <= item.pot_value;
		end
	end

	assign sine_phase    = sine_phase_q;
	assign carrier_phase = carrier_phase_q;

endmodule

FILE: hw/rtl/spwm_wave.sv
module spwm_wave (
	input  logic                               clk,
	input  logic                               en,
	input  logic [spwm_pkg::PHASE_BITS-1:0]    sine_phase,
	input  logic [spwm_pkg::PHASE_BITS-1:0]    carrier_phase,
	input  logic                               step_changed,
	output spwm_pkg::wave_t                    wave
);
	import spwm_pkg::*;

	localparam int TRI_SHL = (PHASE_BITS < 32) ? 32 - PHASE_BITS : 0;
	localparam int TRI_SHR = (PHASE_BITS >= 32) ? PHASE_BITS - 32 : 0;

	wave_t                  wave_s1;
	wave_t                  wave_d;
	logic [PHASE_BITS-1:0]  phase_b;
	logic [PHASE_BITS-1:0]  phase_c;
	logic [PHASE_BITS-2:0]  tri_mag;
	logic [PHASE_BITS+31:0] tri_wide;
	logic [30:0]            tri_q30;
	logic [SAMPLE_BITS+29:0] tri_scaled;

	always_comb begin
		phase_b = sine_phase - PHASE_THIRD;
		phase_c = sine_phase - PHASE_TWO_THIRD;
		wave_d.sa = SINE_LUT[sine_phase[PHASE_BITS-1 -: IDX_BITS]];
		wave_d.sb = SINE_LUT[phase_b[PHASE_BITS-1 -: IDX_BITS]];
		wave_d.sc = SINE_LUT[phase_c[PHASE_BITS-1 -: IDX_BITS]];
		// falling quarters mirror the low bits, second half is negative
		tri_mag = carrier_phase[PHASE_BITS-2] ? -carrier_phase[PHASE_BITS-2:0]
		                                      : carrier_phase[PHASE_BITS-2:0];
		tri_wide = ((PHASE_BITS+32)'(tri_mag) << TRI_SHL) >> TRI_SHR;
		tri_q30 = tri_wide[30:0];
		// times full scale, as a shift and subtract
		tri_scaled = ((SAMPLE_BITS+30)'(tri_q30) << (SAMPLE_BITS - 1))
		           - (SAMPLE_BITS+30)'(tri_q30);
		wave_d.car_mag = tri_scaled[30 +: SAMPLE_BITS-1];
		wave_d.car_neg = carrier_phase[PHASE_BITS-1];
		wave_d.step_changed = step_changed;
	end

	always_ff @(posedge clk) begin
		if (en)
			wave_s1 <= wave_d;
	end

	assign wave = wave_s1;

endmodule

FILE: hw/rtl/spwm_cmp.sv
module spwm_cmp (
	input  logic                              clk,
	input  logic                              en,
	input  spwm_pkg::wave_t                   wave,
	input  logic [spwm_pkg::AMP_BITS-1:0]     sine_amplitude,
	input  logic [spwm_pkg::AMP_BITS-1:0]     carrier_amplitude,
	output spwm_pkg::out_t                    result
);
	import spwm_pkg::*;

	out_t                    result_s2;
	out_t                    result_d;
	logic signed [SAMPLE_BITS-1:0] car;
	logic signed [SAMPLE_BITS-1:0] va;
	logic signed [SAMPLE_BITS-1:0] vb;
	logic signed [SAMPLE_BITS-1:0] vc;

	always_comb begin
		car = scale_amp(wave.car_neg, wave.car_mag, carrier_amplitude);
		va = scale_amp(wave.sa[SAMPLE_BITS-1],
			(SAMPLE_BITS-1)'(wave.sa[SAMPLE_BITS-1] ? -wave.sa : wave.sa), sine_amplitude);
		vb = scale_amp(wave.sb[SAMPLE_BITS-1],
			(SAMPLE_BITS-1)'(wave.sb[SAMPLE_BITS-1] ? -wave.sb : wave.sb), sine_amplitude);
		vc = scale_amp(wave.sc[SAMPLE_BITS-1],
			(SAMPLE_BITS-1)'(wave.sc[SAMPLE_BITS-1] ? -wave.sc : wave.sc), sine_amplitude);
		result_d.pwm_a = va > car;
		result_d.pwm_b = vb > car;
		result_d.pwm_c = vc > car;
		result_d.step_changed = wave.step_changed;
	end

	always_ff @(posedge clk) begin
		if (en)
			result_s2 <= result_d;
	end

	assign result = result_s2;

endmodule

FILE: hw/rtl/three_phase_spwm_generator_top.sv
// three-phase sine pwm: an input transfer reaches out_valid through valid_s1 and valid_s2
// throughput one item per cycle while out_ready is high; sine step, phase advance and
// table lookup in the first stage, amplitude scaling and compare in the second
// arst_n clears valids, phases and last reading, loads sine step and
// configuration registers with their defaults; configuration writes are registered
module three_phase_spwm_generator_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  spwm_pkg::in_t                        in_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output spwm_pkg::out_t                       out_data,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [spwm_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [spwm_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
	import spwm_pkg::*;

	cfg_t                  cfg;
	wave_t                 wave_s1;
	logic [PHASE_BITS-1:0] sine_phase;
	logic [PHASE_BITS-1:0] carrier_phase;
	logic                  step_changed;
	logic                  valid_s1;
	logic                  valid_s2;
	logic                  en_s1;
	logic                  en_s2;
	logic                  in_xfer;

	assign en_s2    = !valid_s2 || out_ready;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;
	assign in_xfer  = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en_s1)
				valid_s1 <= in_valid;
			if (en_s2)
				valid_s2 <= valid_s1;
		end
	end

	spwm_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	spwm_phase u_phase (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (in_xfer),
		.item          (in_data),
		.cfg           (cfg),
		.sine_phase    (sine_phase),
		.carrier_phase (carrier_phase),
		.step_changed  (step_changed)
	);

	spwm_wave u_wave (
		.clk           (clk),
		.en            (en_s1),
		.sine_phase    (sine_phase),
		.carrier_phase (carrier_phase),
		.step_changed  (step_changed),
		.wave          (wave_s1)
	);

	spwm_cmp u_cmp (
		.clk               (clk),
		.en                (en_s2),
		.wave              (wave_s1),
		.sine_amplitude    (cfg.sine_amplitude),
		.carrier_amplitude (cfg.carrier_amplitude),
		.result            (out_data)
	);

	assign out_valid = valid_s2;

	// a ready sink never holds off the source
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output ready");

	// a step change can only come from a transfer that carried a reading
	a_changed_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> valid_s1 && (!wave_s1.step_changed || $past(in_data.pot_valid)))
		else $error("stage 1 item lost or step change without reading");

	// both stages full and output blocked stops input
	a_full_block: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !out_ready) |-> !in_ready)
		else $error("input accepted into full pipeline");

endmodule
